### rtl/core/sufind_pkg.sv
// Package for the segmentation union-find tree unit.
// Holds widths, register indexes and reset constants; no dependencies.
package sufind_pkg;
  localparam int NodeBits = 16;
  localparam int NodeCount = 1 << NodeBits;
  localparam int SizeBits = 17;
  localparam int WeightBits = 16;
  localparam int SlotBits = 16;
  localparam int CountBits = 18;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 18;

  localparam logic [CfgIdxBits-1:0] REG_MERGE = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_NODE_TOP = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_EDGES = 2'd2;

  localparam logic [15:0] MERGE_RESET = 16'd1200;
  localparam logic [NodeBits-1:0] NODE_TOP_RESET = '1;
  localparam logic [CountBits-1:0] EDGES_RESET = 18'd1;
  localparam logic [SizeBits-1:0] SIZE_SAT = '1;

  typedef logic [NodeBits-1:0] node_t;
endpackage

### rtl/core/segmentation_union_find_tree_unit.sv
// Top level of the segmentation union-find tree unit.
// Depends on sufind_pkg; holds the node memory and the edge sequencer.
module segmentation_union_find_tree_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [sufind_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [sufind_pkg::CfgDataBits-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] node_a,
  input  logic [15:0] node_b,
  input  logic [15:0] edge_weight,
  output logic out_valid,
  input  logic out_ready,
  output logic accepted,
  output logic [15:0] tree_slot,
  output logic plain_pass
);
  // After reset a clearing pass initialises the node memory before the first
  // edge is taken. An edge then walks both find paths through the node memory,
  // and every link on either path adds a walk read and a compression write. An
  // edge inside one component skips the size check and the join, and an edge
  // with an endpoint above node_top goes straight to the output. The result
  // waits in an output register while the next edge is processed; that edge's
  // result waits until the register is taken.
  import sufind_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001, S_IDLE = 14'b00000000000010,
    S_RDA   = 14'b00000000000100, S_WKA  = 14'b00000000001000,
    S_CPA   = 14'b00000000010000, S_CPAW = 14'b00000000100000,
    S_RDB   = 14'b00000001000000, S_WKB  = 14'b00000010000000,
    S_CPB   = 14'b00000100000000, S_CPBW = 14'b00001000000000,
    S_CHK   = 14'b00010000000000, S_MUL  = 14'b00100000000000,
    S_JOIN  = 14'b01000000000000, S_OUT  = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic [NodeBits-1:0] parent;
    logic [SizeBits-1:0] size;
    logic [WeightBits-1:0] heavy;
  } entry_t;

  entry_t mem [NodeCount];
  entry_t rdata;
  logic [NodeBits-1:0] raddr, waddr;
  logic re, we;
  entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  state_t state;
  logic [15:0] merge_constant;
  node_t node_top;
  logic [CountBits-1:0] edges_per_pass, edge_counter;
  logic second_pass;
  logic [SlotBits-1:0] tree_count;
  node_t ea, eb, cur, root, ra, rb;
  logic [WeightBits-1:0] w;
  logic pass_r, in_range;
  entry_t ent_a, ent_b;
  logic [NodeBits-1:0] clr;
  logic fit_a_trivial, fit_b_trivial;
  logic [32:0] prod_a, prod_b;
  logic [SizeBits:0] sum;
  logic join_ok;
  logic link_pending;
  logic res_acc;
  logic [SlotBits-1:0] res_slot;

  assign in_ready = (state == S_IDLE);

  assign join_ok = pass_r ||
    ((fit_a_trivial || prod_a <= 33'(merge_constant)) &&
     (fit_b_trivial || prod_b <= 33'(merge_constant)));

  // Read port control.
  always_comb begin
    re = 1'b0;
    raddr = cur;
    unique case (state)
      S_RDA, S_WKA, S_CPA, S_CPAW, S_RDB, S_WKB, S_CPB, S_CPBW: re = 1'b1;
      S_CHK: begin re = 1'b1; raddr = ra; end
      default: re = 1'b0;
    endcase
  end

  always_comb begin
    sum = {1'b0, ent_a.size} + {1'b0, ent_b.size};
  end

  // Write port control.
  always_comb begin
    we = 1'b0;
    waddr = cur;
    wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = '{parent: clr, size: SizeBits'(1), heavy: '0};
      end
      S_CPAW, S_CPBW: begin
        we = (rdata.parent != root);
        wdata.parent = root;
      end
      S_JOIN: begin
        if (join_ok) begin
          we = 1'b1;
          waddr = rb;
          wdata.parent = ent_b.parent;
          wdata.size = sum[SizeBits] ? SIZE_SAT : sum[SizeBits-1:0];
          wdata.heavy = ent_b.heavy;
          if (ent_a.heavy > wdata.heavy) wdata.heavy = ent_a.heavy;
          if (w > wdata.heavy) wdata.heavy = w;
        end
      end
      S_OUT: begin
        we = link_pending;
        waddr = ra;
        wdata = ent_a;
        wdata.parent = rb;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      merge_constant <= MERGE_RESET;
      node_top <= NODE_TOP_RESET;
      edges_per_pass <= EDGES_RESET;
      edge_counter <= '0;
      second_pass <= 1'b0;
      tree_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MERGE: merge_constant <= cfg_data[15:0];
          REG_NODE_TOP: node_top <= cfg_data[NodeBits-1:0];
          REG_EDGES: edges_per_pass <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          ea <= node_a;
          eb <= node_b;
          w <= edge_weight;
          pass_r <= second_pass;
          in_range <= (node_a <= node_top) && (node_b <= node_top);
          cur <= node_a;
          res_acc <= 1'b0;
          res_slot <= '0;
          if (!second_pass) begin
            if (edge_counter + 1'b1 >= edges_per_pass ||
                edge_counter + 1'b1 == '0) begin
              second_pass <= 1'b1;
              edge_counter <= '0;
            end else begin
              edge_counter <= edge_counter + 1'b1;
            end
          end
          state <= S_RDA;
        end
        S_RDA: state <= in_range ? S_WKA : S_OUT;
        S_WKA: if (rdata.parent == cur) begin
          root <= cur;
          ra <= cur;
          cur <= ea;
          state <= S_CPA;
        end else begin
          cur <= rdata.parent;
          state <= S_RDA;
        end
        S_CPA: state <= S_CPAW;
        S_CPAW: if (cur == root) begin
          cur <= eb;
          state <= S_RDB;
        end else begin
          cur <= rdata.parent;
          state <= S_CPA;
        end
        S_RDB: state <= S_WKB;
        S_WKB: if (rdata.parent == cur) begin
          root <= cur;
          rb <= cur;
          cur <= eb;
          ent_b <= rdata;
          state <= S_CPB;
        end else begin
          cur <= rdata.parent;
          state <= S_RDB;
        end
        S_CPB: state <= S_CPBW;
        S_CPBW: if (cur == root) begin
          state <= (ra == rb) ? S_OUT : S_CHK;
        end else begin
          cur <= rdata.parent;
          state <= S_CPB;
        end
        S_CHK: begin
          fit_b_trivial <= (w <= ent_b.heavy);
          prod_b <= {17'd0, w - ent_b.heavy} * {16'd0, ent_b.size};
          state <= S_MUL;
        end
        S_MUL: begin
          ent_a <= rdata;
          fit_a_trivial <= (w <= rdata.heavy);
          prod_a <= {17'd0, w - rdata.heavy} * {16'd0, rdata.size};
          state <= S_JOIN;
        end
        S_JOIN: begin
          if (join_ok) begin
            tree_count <= tree_count + 1'b1;
            res_slot <= tree_count + 1'b1;
            res_acc <= 1'b1;
          end else begin
            res_acc <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          accepted <= res_acc;
          tree_slot <= res_slot;
          plain_pass <= pass_r;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The parent of ra becomes rb only on acceptance, in the cycle after the join.
  always_ff @(posedge clk) begin
    if (rst) link_pending <= 1'b0;
    else link_pending <= (state == S_JOIN) && join_ok;
  end
endmodule

### rtl/core/sufind_checker.sv
// Port-level checker for the segmentation union-find tree unit.
// Depends on sufind_pkg; bound to the top level below.
module sufind_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic accepted,
  input logic [15:0] tree_slot
);
  import sufind_pkg::*;

  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> tree_slot == '0) else $error("slot on rejected edge");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tree_slot) && $stable(accepted))
    else $error("result beat dropped or changed");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second edge taken");
endmodule

bind segmentation_union_find_tree_unit sufind_checker u_sufind_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
  .tree_slot(tree_slot)
);
